[rtl/core/rect_collision_tester_macros.svh]
// Assertion macros for the rectangle collision tester.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef RECT_COLLISION_TESTER_MACROS_SVH
`define RECT_COLLISION_TESTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define RCT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rct check failed");
// Next-cycle implication
`define RCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rct check failed");
`else
`define RCT_ASSERT_NOW(name, ante, cons)
`define RCT_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/core/rct_pkg.sv]
// Shared types and constants for the rectangle collision tester.
// No dependencies.
`timescale 1ns / 1ps
package rct_pkg;

  // Coordinate format: signed Q12.4
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;  // difference of two coordinates
  localparam int EXT_BITS   = COORD_BITS + 2;  // corner minus coordinate
  localparam int PROD_BITS  = DIFF_BITS + EXT_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;

  // Stream packing
  localparam int IN_FIELD_BITS = 4 * COORD_BITS + 2 * SIZE_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 8;

  localparam int FX_LSB = 0;
  localparam int FY_LSB = FX_LSB + COORD_BITS;
  localparam int SX_LSB = FY_LSB + COORD_BITS;
  localparam int SY_LSB = SX_LSB + COORD_BITS;
  localparam int OW_LSB = SY_LSB + COORD_BITS;
  localparam int OH_LSB = OW_LSB + SIZE_BITS;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = COORD_BITS;

  // Job queue
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam int NUM_CORNERS = 4;

  // Corners visited clockwise from top-left, closing on the start
  localparam logic [1:0] EDGE_ORDER [0:NUM_CORNERS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOX_LEFT   = 2'd0,
    REG_BOX_TOP    = 2'd1,
    REG_BOX_WIDTH  = 2'd2,
    REG_BOX_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [IN_USER_BITS-1:0] {
    MODE_POINT   = 2'd0,
    MODE_SEGMENT = 2'd1,
    MODE_BOX     = 2'd2
  } mode_t;

  // Classified query handed from front to back
  typedef struct packed {
    logic                        is_seg;
    logic                        direct_hit;
    logic [NUM_CORNERS-1:0]      edge_ok;
    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic signed [EXT_BITS-1:0]  ey_top;
    logic signed [EXT_BITS-1:0]  ey_bot;
    logic signed [EXT_BITS-1:0]  ex_left;
    logic signed [EXT_BITS-1:0]  ex_right;
  } job_t;

endpackage

[rtl/core/rect_collision_tester.sv]
// Rectangle collision tester: top level.
// Depends on rct_pkg, rct_front, rct_fifo and rct_back.
//
// Usage:
//   Configure the rectangle through cfg_we / cfg_index / cfg_data while no
//   query is in flight: index 0 left, 1 top, 2 width, 3 height (Q12.4).
//   Queries enter on the s_ stream: s_tuser holds the query kind
//   (point, segment, box), s_tdata the coordinates and sizes.
//   Each query produces exactly one transfer on the m_ stream, bit 0 = hit.
// Timing:
//   One query per cycle sustained while m_tready is high. A query accepted
//   on s_ passes the input register, job queue, product stage, sign stage
//   and output register to m_tvalid. The back end's single multiply
//   stage (eight 17x18 products in parallel) sets the stage depth.
// Reset:
//   rst is synchronous; it empties all stages and the queue and clears the
//   rectangle to zero size at the origin.
// Stall:
//   With m_tready low the back end holds its result and fills; the four-entry
//   queue then absorbs the front end before s_tready drops. Nothing is lost.
`timescale 1ns / 1ps
module rect_collision_tester (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [rct_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rct_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // query stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // first_x, first_y, second_x, second_y, other_width, other_height, zero pad
  input  logic [rct_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // mode
  input  logic [rct_pkg::IN_USER_BITS-1:0]  s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // hit, zero pad
  output logic [rct_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import rct_pkg::*;

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  job_t fr_job, bk_job;

  rct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  rct_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_job    (fr_job),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_job   (bk_job)
  );

  rct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[rtl/core/rct_front.sv]
// Front end: configuration registers, input register and query classification.
// Depends on rct_pkg.
`timescale 1ns / 1ps
module rct_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rct_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rct_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rct_pkg::IN_DATA_BITS-1:0] s_tdata,
  input  logic [rct_pkg::IN_USER_BITS-1:0] s_tuser,
  output logic                             job_valid,
  input  logic                             job_ready,
  output rct_pkg::job_t                    job
);
  import rct_pkg::*;

  logic signed [COORD_BITS-1:0] box_left, box_top;
  logic [SIZE_BITS-1:0]         box_width, box_height;
  logic signed [DIFF_BITS-1:0]  box_right, box_bottom;

  logic                         item_valid;
  mode_t                        item_mode;
  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [SIZE_BITS-1:0]         ow, oh;

  logic signed [EXT_BITS-1:0] x1e, y1e, x2e, y2e, le, te, re, be, owe, ohe;
  logic point_hit, box_hit;

  // strictly opposite sides of c
  function automatic logic opposite(input logic signed [EXT_BITS-1:0] a,
                                    input logic signed [EXT_BITS-1:0] b,
                                    input logic signed [EXT_BITS-1:0] c);
    return ((a < c) && (b > c)) || ((a > c) && (b < c));
  endfunction

  // Configuration registers; far edges are registered from the stored values and follow in the cycle after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_top    <= '0;
      box_width  <= '0;
      box_height <= '0;
      box_right  <= '0;
      box_bottom <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BOX_LEFT:   box_left   <= cfg_data[COORD_BITS-1:0];
          REG_BOX_TOP:    box_top    <= cfg_data[COORD_BITS-1:0];
          REG_BOX_WIDTH:  box_width  <= cfg_data[SIZE_BITS-1:0];
          REG_BOX_HEIGHT: box_height <= cfg_data[SIZE_BITS-1:0];
        endcase
      end
      box_right  <= $signed({box_left[COORD_BITS-1], box_left}) + $signed({2'b00, box_width});
      box_bottom <= $signed({box_top[COORD_BITS-1], box_top}) + $signed({2'b00, box_height});
    end
  end

  // Input register
  assign s_tready = !item_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_mode <= mode_t'(s_tuser);
      x1 <= s_tdata[FX_LSB +: COORD_BITS];
      y1 <= s_tdata[FY_LSB +: COORD_BITS];
      x2 <= s_tdata[SX_LSB +: COORD_BITS];
      y2 <= s_tdata[SY_LSB +: COORD_BITS];
      ow <= s_tdata[OW_LSB +: SIZE_BITS];
      oh <= s_tdata[OH_LSB +: SIZE_BITS];
    end
  end

  // Sign extension to a common width
  always_comb begin
    x1e = {{2{x1[COORD_BITS-1]}}, x1};
    y1e = {{2{y1[COORD_BITS-1]}}, y1};
    x2e = {{2{x2[COORD_BITS-1]}}, x2};
    y2e = {{2{y2[COORD_BITS-1]}}, y2};
    le  = {{2{box_left[COORD_BITS-1]}}, box_left};
    te  = {{2{box_top[COORD_BITS-1]}}, box_top};
    re  = {box_right[DIFF_BITS-1], box_right};
    be  = {box_bottom[DIFF_BITS-1], box_bottom};
    owe = {{(EXT_BITS-SIZE_BITS){1'b0}}, ow};
    ohe = {{(EXT_BITS-SIZE_BITS){1'b0}}, oh};
  end

  // Point: half-open on right and bottom. Box: touching counts.
  assign point_hit = (x1e >= le) && (y1e >= te) && (x1e < re) && (y1e < be);
  assign box_hit   = (x1e <= re) && ((x1e + owe) >= le) &&
                     (y1e <= be) && ((y1e + ohe) >= te);

  // Classify and prepare cross-product operands
  always_comb begin
    job.is_seg     = 1'b0;
    job.direct_hit = 1'b0;
    unique case (item_mode)
      MODE_POINT:   job.direct_hit = point_hit;
      MODE_SEGMENT: job.is_seg     = 1'b1;
      MODE_BOX:     job.direct_hit = box_hit;
      default:      job.direct_hit = 1'b0;
    endcase
    // Segment endpoints on strictly opposite sides of each edge line
    job.edge_ok[0] = (box_width != '0)  && opposite(y1e, y2e, te);
    job.edge_ok[1] = (box_height != '0) && opposite(x1e, x2e, re);
    job.edge_ok[2] = (box_width != '0)  && opposite(y1e, y2e, be);
    job.edge_ok[3] = (box_height != '0) && opposite(x1e, x2e, le);
    job.dx       = $signed({x1[COORD_BITS-1], x1}) - $signed({x2[COORD_BITS-1], x2});
    job.dy       = $signed({y1[COORD_BITS-1], y1}) - $signed({y2[COORD_BITS-1], y2});
    job.ey_top   = te - y1e;
    job.ey_bot   = be - y1e;
    job.ex_left  = x1e - le;
    job.ex_right = x1e - re;
  end

  assign job_valid = item_valid;

endmodule

[rtl/core/rct_fifo.sv]
// Short job queue between front and back ends.
// Depends on rct_pkg and rect_collision_tester_macros.svh.
`timescale 1ns / 1ps
`include "rect_collision_tester_macros.svh"
module rct_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rct_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output rct_pkg::job_t out_job
);
  import rct_pkg::*;

  job_t                   slots [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_BITS:0]   count;
  logic                   push, pop;

  assign in_ready  = (count != (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_job;
  end

  `RCT_ASSERT_NOW(a_fifo_bound, 1'b1, count <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH))
  `RCT_ASSERT_NEXT(a_fifo_grow, push && !pop, count == $past(count) + 1'b1)

endmodule

[rtl/core/rct_back.sv]
// Back end: corner cross products, sign extraction and hit decision.
// Depends on rct_pkg and rect_collision_tester_macros.svh.
`timescale 1ns / 1ps
`include "rect_collision_tester_macros.svh"
module rct_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  rct_pkg::job_t                     job,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rct_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import rct_pkg::*;

  logic signed [EXT_BITS-1:0] cy [NUM_CORNERS];
  logic signed [EXT_BITS-1:0] cx [NUM_CORNERS];

  // stage 1: products
  logic                        s1_valid, s1_is_seg, s1_direct;
  logic [NUM_CORNERS-1:0]      s1_edge_ok;
  logic signed [PROD_BITS-1:0] prod_a [NUM_CORNERS];
  logic signed [PROD_BITS-1:0] prod_b [NUM_CORNERS];

  // stage 2: signs
  logic                    s2_valid, s2_is_seg, s2_direct;
  logic [NUM_CORNERS-1:0]  s2_edge_ok, s2_neg, s2_pos;
  logic signed [SUM_BITS-1:0] sums [NUM_CORNERS];

  logic s1_ready, s2_ready, s3_ready;
  logic seg_hit, out_hit;

  assign s3_ready  = !m_tvalid || m_tready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign job_ready = s1_ready;

  // Corner operands: top corners use the top row, left corners the left column
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      cy[k] = (k < 2) ? job.ey_top : job.ey_bot;
      cx[k] = (k == 0 || k == 3) ? job.ex_left : job.ex_right;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && job_valid) begin
      s1_is_seg  <= job.is_seg;
      s1_direct  <= job.direct_hit;
      s1_edge_ok <= job.edge_ok;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        prod_a[k] <= PROD_BITS'(job.dx) * PROD_BITS'(cy[k]);
        prod_b[k] <= PROD_BITS'(job.dy) * PROD_BITS'(cx[k]);
      end
    end
  end

  // Stage 2: exact sum, keep only the sign
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      sums[k] = SUM_BITS'(prod_a[k]) + SUM_BITS'(prod_b[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_is_seg  <= s1_is_seg;
      s2_direct  <= s1_direct;
      s2_edge_ok <= s1_edge_ok;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        s2_neg[k] <= sums[k][SUM_BITS-1];
        s2_pos[k] <= !sums[k][SUM_BITS-1] && (sums[k] != '0);
      end
    end
  end

  // Edge crossed when its end corners lie strictly on opposite sides of the segment
  always_comb begin
    seg_hit = 1'b0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      seg_hit = seg_hit || (s2_edge_ok[i] &&
                ((s2_neg[EDGE_ORDER[i+1]] && s2_pos[EDGE_ORDER[i]]) ||
                 (s2_pos[EDGE_ORDER[i+1]] && s2_neg[EDGE_ORDER[i]])));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s3_ready) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      out_hit <= s2_is_seg ? seg_hit : s2_direct;
    end
  end

  assign m_tdata = {{(OUT_DATA_BITS-1){1'b0}}, out_hit};

  `RCT_ASSERT_NEXT(a_s1_moves, s1_valid && s2_ready, s2_valid)
  `RCT_ASSERT_NEXT(a_s2_moves, s2_valid && s3_ready, m_tvalid)

endmodule

[tb/tb_rect_collision_tester.sv]
// Self-checking testbench for rect_collision_tester: point, segment, box and unused-mode queries
// against a programmed rectangle, checked against a behavioral hit predictor.
// Depends on rct_pkg and the rect_collision_tester RTL.
`timescale 1ns / 1ps
module tb_rect_collision_tester;
  import rct_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 244;

  typedef struct {
    logic [1:0]                  mode;
    logic signed [COORD_BITS-1:0] fx, fy, sx, sy;
    logic [SIZE_BITS-1:0]        ow, oh;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;  // first_x, first_y, second_x, second_y, other_w/h
  logic [IN_USER_BITS-1:0]  s_tuser = '0;  // mode
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;       // hit, zero pad

  // Shadow copy of the rectangle registers
  logic signed [COORD_BITS-1:0] box_left = '0, box_top = '0;
  logic [SIZE_BITS-1:0]         box_width = '0, box_height = '0;

  query_t query_q[$];
  query_t offered;
  bit     hit_q[$];
  bit     exp_hit;
  int     queued_total = 0;
  int     results_seen = 0;
  int     failures = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_req = 0, hold_served = 0, hold_left = 0;
  int     quiet_cycles = 0;

  rect_collision_tester u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int sign_of(longint v);
    if (v < 0) return -1;
    if (v == 0) return 0;
    return 1;
  endfunction

  // Expected hit for one query against the current rectangle
  function automatic bit predict_hit(query_t q);
    longint l, t, w, h, x1, y1, x2, y2, ow, oh;
    longint cx[4], cy[4];
    longint ax, ay, bx, by;
    int sa, sb, sc, sd;
    l = box_left; t = box_top; w = box_width; h = box_height;
    x1 = q.fx; y1 = q.fy; x2 = q.sx; y2 = q.sy; ow = q.ow; oh = q.oh;
    case (q.mode)
      MODE_POINT:
        return x1 >= l && y1 >= t && x1 < l + w && y1 < t + h;
      MODE_BOX:
        return x1 <= l + w && x1 + ow >= l && y1 <= t + h && y1 + oh >= t;
      MODE_SEGMENT: begin
        // corners clockwise from top-left
        cx[0] = l;     cy[0] = t;
        cx[1] = l + w; cy[1] = t;
        cx[2] = l + w; cy[2] = t + h;
        cx[3] = l;     cy[3] = t + h;
        for (int i = 0; i < 4; i++) begin
          ax = cx[i]; ay = cy[i];
          bx = cx[(i + 1) % 4]; by = cy[(i + 1) % 4];
          sa = sign_of((x1 - x2) * (by - y1) + (y1 - y2) * (x1 - bx));
          sb = sign_of((x1 - x2) * (ay - y1) + (y1 - y2) * (x1 - ax));
          sc = sign_of((bx - ax) * (y1 - by) + (by - ay) * (bx - x1));
          sd = sign_of((bx - ax) * (y2 - by) + (by - ay) * (bx - x2));
          // strictly opposite on both tests: a proper crossing
          if (sa * sb < 0 && sc * sd < 0) return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic query_t mk(logic [1:0] m, int fx, int fy, int sx, int sy,
                                int ow, int oh);
    query_t q;
    q.mode = m;
    q.fx = 16'(fx); q.fy = 16'(fy); q.sx = 16'(sx); q.sy = 16'(sy);
    q.ow = 15'(ow); q.oh = 15'(oh);
    return q;
  endfunction

  // Pack the coordinate fields of a query into tdata, zero padded
  function automatic logic [IN_DATA_BITS-1:0] pack_data(query_t q);
    logic [IN_DATA_BITS-1:0] d;
    d = '0;
    d[FX_LSB +: COORD_BITS] = q.fx;
    d[FY_LSB +: COORD_BITS] = q.fy;
    d[SX_LSB +: COORD_BITS] = q.sx;
    d[SY_LSB +: COORD_BITS] = q.sy;
    d[OW_LSB +: SIZE_BITS]  = q.ow;
    d[OH_LSB +: SIZE_BITS]  = q.oh;
    return d;
  endfunction

  // Coordinate near a reference edge, sometimes anywhere
  function automatic logic signed [COORD_BITS-1:0] near_coord(longint c);
    longint v;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: v = c + longint'($urandom_range(8)) - 4;
      2: v = c + longint'($urandom_range(128)) - 64;
      default: v = c + longint'($urandom_range(4096)) - 2048;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [SIZE_BITS-1:0] rand_size(longint s);
    longint v;
    case ($urandom_range(3))
      0: return 15'($urandom);
      1: return 15'($urandom_range(64));
      default: v = s + longint'($urandom_range(64)) - 32;
    endcase
    if (v > 32767) v = 32767;
    if (v < 0) v = 0;
    return 15'(v);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    longint l, t, r, b;
    int pick;
    l = box_left; t = box_top;
    r = l + box_width; b = t + box_height;
    pick = $urandom_range(19);
    if (pick == 0) q.mode = MODE_UNUSED;
    else if (pick < 7) q.mode = MODE_POINT;
    else if (pick < 14) q.mode = MODE_SEGMENT;
    else q.mode = MODE_BOX;
    q.fx = near_coord($urandom_range(1) ? l : r);
    q.fy = near_coord($urandom_range(1) ? t : b);
    q.sx = near_coord($urandom_range(1) ? l : r);
    q.sy = near_coord($urandom_range(1) ? t : b);
    q.ow = rand_size(box_width);
    q.oh = rand_size(box_height);
    return q;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_BOX_LEFT:   box_left = val;
      REG_BOX_TOP:    box_top = val;
      REG_BOX_WIDTH:  box_width = val[SIZE_BITS-1:0];
      REG_BOX_HEIGHT: box_height = val[SIZE_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(logic [15:0] l, logic [15:0] t, logic [14:0] w, logic [14:0] h);
    write_reg(REG_BOX_LEFT, l);
    write_reg(REG_BOX_TOP, t);
    write_reg(REG_BOX_WIDTH, {1'b0, w});
    write_reg(REG_BOX_HEIGHT, {1'b0, h});
  endtask

  task automatic send(query_t q);
    query_q.push_back(q);
    queued_total++;
  endtask

  // Block until every queued query has produced its result
  task automatic wait_drained();
    while (results_seen < queued_total) @(posedge clk);
  endtask

  // Query driver: holds tvalid until the transfer, then offers the next queued item or idles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) hit_q.push_back(predict_hit(offered));
      if (query_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = query_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= offered.mode;
        s_tdata <= pack_data(offered);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (hit_q.size() == 0) begin
          $error("hit: no result expected, actual %0b", m_tdata[0]);
          failures++;
        end else begin
          exp_hit = hit_q.pop_front();
          if (m_tdata[0] !== exp_hit) begin
            $error("hit: expected %0b, actual %0b", exp_hit, m_tdata[0]);
            failures++;
          end
        end
      end
      if (hold_left == 0 && hold_req != hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_rect_collision_tester NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Rectangle after reset: zero size at the origin
    send(mk(MODE_POINT, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_BOX, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_SEGMENT, -16, -16, 16, 16, 0, 0));
    send(mk(MODE_UNUSED, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Rectangle x in [-160, 160], y in [-80, 80]
    set_box(-16'sd160, -16'sd80, 15'd320, 15'd160);
    send(mk(MODE_POINT, -160, -80, 0, 0, 0, 0));           // top-left corner is inside
    send(mk(MODE_POINT, 160, 0, 0, 0, 0, 0));              // right edge excluded
    send(mk(MODE_POINT, 0, 80, 0, 0, 0, 0));               // bottom edge excluded
    send(mk(MODE_POINT, 159, 79, 0, 0, 0, 0));
    send(mk(MODE_POINT, 32767, 32767, 0, 0, 0, 0));
    send(mk(MODE_POINT, -32768, -32768, 0, 0, 0, 0));
    send(mk(MODE_SEGMENT, -200, 0, 0, 0, 0, 0));           // crosses left edge
    send(mk(MODE_SEGMENT, -100, -10, 100, 10, 0, 0));      // wholly inside
    send(mk(MODE_SEGMENT, -200, -120, -120, -40, 0, 0));   // through a corner
    send(mk(MODE_SEGMENT, -200, -80, 200, -80, 0, 0));     // collinear with top edge
    send(mk(MODE_SEGMENT, 0, -200, 0, 200, 0, 0));         // crosses top and bottom
    send(mk(MODE_SEGMENT, -32768, -32768, 32767, 32767, 0, 0));
    send(mk(MODE_SEGMENT, 32767, -32768, -32768, 32767, 0, 0));
    send(mk(MODE_BOX, 160, 80, 0, 0, 0, 0));               // touches bottom-right corner
    send(mk(MODE_BOX, 161, 0, 0, 0, 10, 10));
    send(mk(MODE_BOX, -32768, -32768, 0, 0, 32767, 32767));
    send(mk(MODE_BOX, -32768, -32768, 0, 0, 0, 0));
    send(mk(MODE_UNUSED, 32767, -32768, 32767, -32768, 32767, 32767));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_box(16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF);
        1: set_box(16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF);
        2: set_box(16'h0000, 16'h0000, 15'h0000, 15'h0000);
        default: set_box(16'($urandom), 16'($urandom),
                         $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(2048)),
                         $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(2048)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 4) hold_req++;
      // two halves; the sender waits for every result in between
      for (int half = 0; half < 2; half++) begin
        for (int i = 0; i < PHASE_ITEMS / 2; i++) send(rand_query());
        wait_drained();
      end
    end

    repeat (20) @(posedge clk);
    if (hit_q.size() != 0) begin
      $error("hit: %0d results never arrived", hit_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tb_rect_collision_tester OK");
    end else begin
      $display("tb_rect_collision_tester NOT OK");
    end
    $finish;
  end

endmodule
